### rtl/core/iirdf2_pkg.sv
// Shared types, widths and rounding helpers for the direct form II IIR filter.
package iirdf2_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int WORD_W    = 24;
   localparam int FRAC_W    = 20;
   localparam int PROD_W    = COEF_W + WORD_W;
   localparam int ACC_W     = 52;
   localparam int RND_W     = ACC_W - FRAC_W;
   localparam int MAX_ORDER = 3;
   localparam int ORDER_DEF = 3;
   localparam int INDEX_W   = 3;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

   localparam logic signed [RND_W-1:0] WORD_MAX   = RND_W'((1 << (WORD_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] WORD_MIN   = -RND_W'(1 << (WORD_W - 1));
   localparam logic signed [RND_W-1:0] SAMPLE_MAX = RND_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAMPLE_MIN = -RND_W'(1 << (SAMPLE_W - 1));

   typedef enum logic [INDEX_W-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_B3 = 3'd3,
      REG_A1 = 3'd4,
      REG_A2 = 3'd5,
      REG_A3 = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic sub;
   } mac_ctrl_type;

   // add one half LSB, then floor shift
   function automatic logic signed [RND_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + ACC_W'(1 << (FRAC_W - 1));
      return RND_W'(t >>> FRAC_W);
   endfunction

endpackage

### rtl/core/iirdf2_mac.sv
// Shared multiply-accumulate unit: registered product, then signed accumulate.
module iirdf2_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iirdf2_pkg::mac_ctrl_type               ctrl,
   input  logic signed [iirdf2_pkg::ACC_W-1:0]    load_val,
   input  logic signed [iirdf2_pkg::COEF_W-1:0]   op_coef,
   input  logic signed [iirdf2_pkg::WORD_W-1:0]   op_word,
   output logic signed [iirdf2_pkg::ACC_W-1:0]    acc
);
   import iirdf2_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic                     prod_sub_ff, prod_sub_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_in     = op_coef * op_word;
   assign prod_vld_in = ctrl.issue;
   assign prod_sub_in = ctrl.sub;
   assign prod_ext    = ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = load_val;
      end else if (prod_vld_ff) begin
         acc_in = prod_sub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         prod_sub_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         prod_sub_ff <= prod_sub_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/core/iir_direct_form_two_filter_unit.sv
// Direct form II IIR filter top level: coefficient registers, delay line, MAC sequencer.
// One sample is taken at a time: req_tready is high only while idle, and the single
// shared 24x24 multiply-accumulate unit does every tap in turn. A result not yet
// taken by the receiver holds the sequencer in its output rounding step.
// Reset: synchronous, active high; coef_b0 = 1.0, other coefficients and
// the delay line clear to zero, no result pending.
module iir_direct_form_two_filter_unit #(
   parameter int ORDER = iirdf2_pkg::ORDER_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [iirdf2_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] sample_in
   input  logic                                  req_tlast,   // block_end
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [iirdf2_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] sample_out
   output logic                                  rsp_tuser,   // [0] saturated
   output logic                                  rsp_tlast,   // block_end_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [iirdf2_pkg::INDEX_W-1:0]        csr_index,
   input  logic [iirdf2_pkg::COEF_W-1:0]         csr_data
);
   import iirdf2_pkg::*;

   localparam int N      = (ORDER < 1) ? 1 : ((ORDER > MAX_ORDER) ? MAX_ORDER : ORDER);
   localparam int STEP_W = $clog2(N + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_W_MUL,
      S_W_DRAIN,
      S_W_ROUND,
      S_Y_MUL,
      S_Y_DRAIN,
      S_Y_ROUND
   } state_type;

   state_type                 state_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [COEF_W-1:0]  b_ff [MAX_ORDER+1];
   logic signed [COEF_W-1:0]  a_ff [MAX_ORDER];
   logic signed [WORD_W-1:0]  delay_ff [N];
   logic signed [WORD_W-1:0]  w_ff;
   logic                      sat_ff;
   logic                      last_ff;
   logic                      rsp_valid_ff;
   logic [SAMPLE_W-1:0]       rsp_data_ff;
   logic                      rsp_sat_ff;
   logic                      rsp_last_ff;

   mac_ctrl_type              mac_ctrl;
   logic signed [ACC_W-1:0]   mac_load;
   logic signed [COEF_W-1:0]  op_coef;
   logic signed [WORD_W-1:0]  op_word;
   logic signed [ACC_W-1:0]   acc;
   logic signed [RND_W-1:0]   acc_rnd;
   logic                      accept;
   logic                      out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign acc_rnd    = round_frac(acc);

   always_comb begin
      mac_ctrl = '0;
      mac_load = '0;
      op_coef  = b_ff[0];
      op_word  = w_ff;
      if (state_ff == S_IDLE && accept) begin
         mac_ctrl.load = 1'b1;
         mac_load      = ACC_W'($signed(req_tdata)) <<< FRAC_W;
      end
      if (state_ff == S_W_ROUND) begin
         mac_ctrl.load = 1'b1;
      end
      if (state_ff == S_W_MUL) begin
         mac_ctrl.issue = 1'b1;
         mac_ctrl.sub   = 1'b1;
      end
      if (state_ff == S_Y_MUL) begin
         mac_ctrl.issue = 1'b1;
      end
      for (int k = 0; k < N; k++) begin
         if (state_ff == S_W_MUL && step_ff == STEP_W'(k)) begin
            op_coef = a_ff[k];
            op_word = delay_ff[k];
         end
         if (state_ff == S_Y_MUL && step_ff == STEP_W'(k + 1)) begin
            op_coef = b_ff[k + 1];
            op_word = delay_ff[k];
         end
      end
   end

   iirdf2_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .load_val (mac_load),
      .op_coef  (op_coef),
      .op_word  (op_word),
      .acc      (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         b_ff[0]      <= COEF_ONE;
         for (int k = 1; k <= MAX_ORDER; k++) begin
            b_ff[k] <= '0;
         end
         for (int k = 0; k < MAX_ORDER; k++) begin
            a_ff[k] <= '0;
         end
         for (int k = 0; k < N; k++) begin
            delay_ff[k] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_B0: b_ff[0] <= csr_data;
               REG_B1: b_ff[1] <= csr_data;
               REG_B2: b_ff[2] <= csr_data;
               REG_B3: b_ff[3] <= csr_data;
               REG_A1: a_ff[0] <= csr_data;
               REG_A2: a_ff[1] <= csr_data;
               REG_A3: a_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_Y_ROUND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (accept) begin
                  last_ff  <= req_tlast;
                  sat_ff   <= 1'b0;
                  state_ff <= S_W_MUL;
               end
            end
            S_W_MUL: begin
               if (step_ff == STEP_W'(N - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_W_DRAIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_W_DRAIN: begin
               state_ff <= S_W_ROUND;
            end
            S_W_ROUND: begin
               if (acc_rnd > WORD_MAX) begin
                  w_ff   <= WORD_W'(WORD_MAX);
                  sat_ff <= 1'b1;
               end else if (acc_rnd < WORD_MIN) begin
                  w_ff   <= WORD_W'(WORD_MIN);
                  sat_ff <= 1'b1;
               end else begin
                  w_ff <= WORD_W'(acc_rnd);
               end
               state_ff <= S_Y_MUL;
            end
            S_Y_MUL: begin
               if (step_ff == STEP_W'(N)) begin
                  step_ff  <= '0;
                  state_ff <= S_Y_DRAIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_Y_DRAIN: begin
               state_ff <= S_Y_ROUND;
            end
            S_Y_ROUND: begin
               if (out_free) begin
                  if (acc_rnd > SAMPLE_MAX) begin
                     rsp_data_ff <= SAMPLE_W'(SAMPLE_MAX);
                     rsp_sat_ff  <= 1'b1;
                  end else if (acc_rnd < SAMPLE_MIN) begin
                     rsp_data_ff <= SAMPLE_W'(SAMPLE_MIN);
                     rsp_sat_ff  <= 1'b1;
                  end else begin
                     rsp_data_ff <= SAMPLE_W'(acc_rnd);
                     rsp_sat_ff  <= sat_ff;
                  end
                  rsp_last_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  delay_ff[0]  <= w_ff;
                  for (int k = 1; k < N; k++) begin
                     delay_ff[k] <= delay_ff[k - 1];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted sample always starts the feedback pass
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_W_MUL)
      else $error("accepted sample did not start feedback pass");

   // a new result appears only out of the output rounding step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_Y_ROUND)
      else $error("result beat raised outside output rounding");

   // delay line moves only when a result is committed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_Y_ROUND) |=> $stable(delay_ff[0]))
      else $error("delay line changed outside commit");

   // step counter never runs past the last feed-forward tap
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_MUL || state_ff == S_Y_MUL) |-> step_ff <= STEP_W'(N))
      else $error("tap step out of range");

endmodule

### test/tb.sv
// Self-checking testbench for the direct form II IIR filter unit.
module tb;
   import iirdf2_pkg::*;

   localparam int TAPS        = ORDER_DEF;
   localparam int REG_COUNT   = 7;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 2 * TAPS + 6;
   localparam logic [INDEX_W-1:0] REG_NONE    = 3'd7;
   localparam logic signed [COEF_W-1:0] COEF_TOP    = 24'sh7FFFFF;
   localparam logic signed [COEF_W-1:0] COEF_BOTTOM = 24'sh800000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                saturated;
      logic                block_end_out;
   } filt_result_type;

   typedef logic signed [COEF_W-1:0] coef_set_type [REG_COUNT];
   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_type;
   typedef enum {KIND_STABLE, KIND_WILD, KIND_TOP, KIND_BOTTOM, KIND_MIXED} coef_kind_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index  = '0;
   logic [COEF_W-1:0]   csr_data   = '0;

   logic signed [COEF_W-1:0] coef_shadow [REG_COUNT];
   longint                   delay_shadow [TAPS];
   filt_result_type          pending_outputs [$];

   int          errors      = 0;
   int          stall_cycles = 0;
   int          burst_left  = 0;
   bit          tx_gaps     = 1'b1;
   rx_mode_type rx_mode     = RX_ALWAYS;
   int          hold_cycles = 0;
   int          rx_run      = 0;
   logic        rx_on       = 1'b1;

   iir_direct_form_two_filter_unit #(.ORDER(TAPS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint round_q20(input longint v);
      return (v + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one sample through the filter; advances the delay line copy
   function automatic filt_result_type filter_step(input logic signed [SAMPLE_W-1:0] x,
                                                   input logic last);
      longint          wsum;
      longint          ysum;
      longint          wr;
      longint          w;
      longint          yr;
      longint          y;
      int              j;
      filt_result_type r;
      wsum = longint'(x) * (64'sd1 <<< FRAC_W);
      ysum = 0;
      for (j = 0; j < TAPS; j++) begin
         wsum -= longint'(coef_shadow[REG_A1 + j]) * delay_shadow[j];
         ysum += longint'(coef_shadow[REG_B1 + j]) * delay_shadow[j];
      end
      wr = round_q20(wsum);
      w  = clamp(wr, longint'(WORD_MIN), longint'(WORD_MAX));
      ysum += longint'(coef_shadow[REG_B0]) * w;
      yr = round_q20(ysum);
      y  = clamp(yr, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
      for (j = TAPS - 1; j > 0; j--)
         delay_shadow[j] = delay_shadow[j - 1];
      delay_shadow[0] = w;
      r.sample_out    = SAMPLE_W'(y);
      r.saturated     = (w != wr) || (y != yr);
      r.block_end_out = last;
      return r;
   endfunction

   // result checking, prediction on accepted inputs, coefficient tracking
   always @(posedge clock) begin
      filt_result_type want;
      if (reset) begin
         foreach (coef_shadow[i]) coef_shadow[i] = '0;
         coef_shadow[REG_B0] = COEF_ONE;
         foreach (delay_shadow[i]) delay_shadow[i] = 0;
         pending_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outputs.size() == 0) begin
               $display("%0t: unexpected result beat, actual sample_out %h saturated %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_tdata !== want.sample_out) begin
                  $display("%0t: sample_out expected %h actual %h",
                           $time, want.sample_out, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b",
                           $time, want.saturated, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== want.block_end_out) begin
                  $display("%0t: block_end_out expected %b actual %b",
                           $time, want.block_end_out, rsp_tlast);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_outputs.push_back(filter_step(req_tdata, req_tlast));
         if (csr_valid && csr_ready && csr_index <= REG_A3)
            coef_shadow[csr_index] = csr_data;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL iir_direct_form_two_filter_unit");
            $finish;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles--;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_tready = 1'b1;
            RX_RANDOM: rsp_tready = ($urandom_range(0, 3) != 0);
            default: begin
               if (rx_run == 0) begin
                  rx_on  = ~rx_on;
                  rx_run = $urandom_range(1, 30);
               end
               rx_run--;
               rsp_tready = rx_on;
            end
         endcase
      end
   end

   // entered and left at a falling edge; valid stays high for a following beat
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = tx_gaps ? $urandom_range(0, 20) : 0;
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = s;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_coefs(input coef_set_type c, input bit stray);
      wait_idle();
      for (int i = 0; i < REG_COUNT; i++)
         write_reg(INDEX_W'(i), c[i]);
      if (stray)
         write_reg(REG_NONE, COEF_W'($urandom));
      csr_valid = 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         1, 2: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_span(input int span);
      return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic test_passthrough();
      int vals [8] = '{32767, -32768, 0, -1, 1, 21845, -21846, 12345};
      rx_mode = RX_ALWAYS;
      tx_gaps = 1'b0;
      for (int i = 0; i < 8; i++)
         send_sample(SAMPLE_W'(vals[i]), i[0]);
   endtask

   task automatic test_corner_coefs();
      coef_set_type c;
      foreach (c[i]) c[i] = '0;
      c[REG_B0] = COEF_TOP;
      load_coefs(c, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h1000, 1'b1);
      // strong positive feedback drives w into its clip
      c[REG_B0] = COEF_ONE;
      c[REG_A1] = COEF_BOTTOM;
      load_coefs(c, 1'b0);
      repeat (4) send_sample(16'h7FFF, 1'b0);
      foreach (c[i]) c[i] = COEF_BOTTOM;
      load_coefs(c, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      foreach (c[i]) c[i] = COEF_TOP;
      load_coefs(c, 1'b1);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0001, 1'b1);
      send_sample(16'h8000, 1'b0);
   endtask

   task automatic test_random_filters();
      coef_kind_type kinds [11] = '{KIND_STABLE, KIND_WILD, KIND_STABLE, KIND_MIXED, KIND_TOP,
                                    KIND_STABLE, KIND_BOTTOM, KIND_WILD, KIND_STABLE,
                                    KIND_MIXED, KIND_STABLE};
      coef_set_type  c;
      foreach (kinds[p]) begin
         case (kinds[p])
            KIND_TOP:    foreach (c[i]) c[i] = COEF_TOP;
            KIND_BOTTOM: foreach (c[i]) c[i] = COEF_BOTTOM;
            KIND_WILD:   foreach (c[i]) c[i] = COEF_W'($urandom);
            default: begin
               for (int i = REG_B0; i <= REG_B3; i++)
                  c[i] = (kinds[p] == KIND_MIXED) ? COEF_W'($urandom) : rand_span(1 << FRAC_W);
               // sum of |a| below one keeps the loop stable
               c[REG_A1] = rand_span(1 << 19);
               c[REG_A2] = rand_span(1 << 18);
               c[REG_A3] = rand_span(1 << 17);
            end
         endcase
         load_coefs(c, $urandom_range(0, 3) == 0);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         tx_gaps = ($urandom_range(0, 3) != 0);
         repeat (60) send_sample(pick_sample(), $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      rx_mode     = RX_ALWAYS;
      tx_gaps     = 1'b0;
      hold_cycles = 400;
      repeat (30) send_sample(pick_sample(), $urandom_range(0, 1));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_passthrough();
      test_corner_coefs();
      test_random_filters();
      test_backpressure();
      wait_idle();
      if (errors == 0)
         $display("PASS iir_direct_form_two_filter_unit");
      else
         $display("FAIL iir_direct_form_two_filter_unit");
      $finish;
   end

endmodule
